FILE: hdl/aes_pkg.sv
package aes_pkg;

   localparam int BLOCK_W = 128;
   localparam int HALF_W  = 64;
   localparam int ROUND_W = 4;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;

   // csr register indexes
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // controller commands to the datapath
   typedef struct packed {
      logic                load;
      logic                step;
      logic                last;
      logic [ROUND_W-1:0]  round;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
      case (r)
         4'd1:    rcon = 8'h01;
         4'd2:    rcon = 8'h02;
         4'd3:    rcon = 8'h04;
         4'd4:    rcon = 8'h08;
         4'd5:    rcon = 8'h10;
         4'd6:    rcon = 8'h20;
         4'd7:    rcon = 8'h40;
         4'd8:    rcon = 8'h80;
         4'd9:    rcon = 8'h1b;
         4'd10:   rcon = 8'h36;
         default: rcon = 8'h00;
      endcase
   endfunction

endpackage

FILE: hdl/aes_ctrl.sv
module aes_ctrl
   import aes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               round_in = 4'd1;
            end
         end
         ST_RUN: begin
            if (round_ff != LAST_ROUND) begin
               round_in = round_ff + 4'd1;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      cmd.last  = (round_ff == LAST_ROUND);
      cmd.round = round_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = !cmd.last || out_free;
         end
         default: ;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.step && cmd.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/aes_dp.sv
module aes_dp
   import aes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [HALF_W-1:0] csr_data,
   input  logic [HALF_W-1:0] req_plain_high,
   input  logic [HALF_W-1:0] req_plain_low,
   input  cmd_type           cmd,
   output logic [HALF_W-1:0] rsp_cipher_high,
   output logic [HALF_W-1:0] rsp_cipher_low
);

   logic [BLOCK_W-1:0] key_ff, key_in;
   logic [BLOCK_W-1:0] state_ff, state_in;
   logic [BLOCK_W-1:0] rk_ff, rk_in;
   logic [BLOCK_W-1:0] out_ff, out_in;
   logic [BLOCK_W-1:0] rk_next, sub_sh, mixed, round_out;
   logic [31:0]        w0, w1, w2, w3, tw;
   logic [7:0]         sb [16];
   logic [7:0]         a0, a1, a2, a3, all;

   // key registers
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_HIGH: key_in[127:64] = csr_data;
            CSR_KEY_LOW:  key_in[63:0]   = csr_data;
            default: ;
         endcase
      end
   end

   // round key schedule, one round key per step
   always_comb begin
      tw = {SBOX[rk_ff[23:16]], SBOX[rk_ff[15:8]], SBOX[rk_ff[7:0]], SBOX[rk_ff[31:24]]};
      w0 = rk_ff[127:96] ^ tw ^ {rcon(cmd.round), 24'h0};
      w1 = rk_ff[95:64] ^ w0;
      w2 = rk_ff[63:32] ^ w1;
      w3 = rk_ff[31:0] ^ w2;
      rk_next = {w0, w1, w2, w3};
   end

   // sub bytes and shift rows
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            sb[r + 4*c] = SBOX[state_ff[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
         end
      end
      for (int i = 0; i < 16; i++) begin
         sub_sh[127 - 8*i -: 8] = sb[i];
      end
   end

   // mix columns
   always_comb begin
      mixed = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = sb[4*c];
         a1  = sb[4*c + 1];
         a2  = sb[4*c + 2];
         a3  = sb[4*c + 3];
         all = a0 ^ a1 ^ a2 ^ a3;
         mixed[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                    a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
      round_out = (cmd.last ? sub_sh : mixed) ^ rk_next;
   end

   // state, round key and result registers
   always_comb begin
      state_in = state_ff;
      rk_in    = rk_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         state_in = {req_plain_high, req_plain_low} ^ key_ff;
         rk_in    = key_ff;
      end else if (cmd.step) begin
         state_in = round_out;
         rk_in    = rk_next;
         if (cmd.last) begin
            out_in = round_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff    <= rk_in;
      out_ff   <= out_in;
   end

   assign rsp_cipher_high = out_ff[127:64];
   assign rsp_cipher_low  = out_ff[63:0];

endmodule

FILE: hdl/aes128_encrypt_block.sv
// AES-128 block encryption, encrypt direction only.
// Key: write key bytes 0..7 at csr_index 0 and bytes 8..15 at csr_index 1
// with csr_wr_en high; both key halves reset to zero. Write only while idle.
// Round keys are generated on the fly next to the rounds, so a new key
// applies to the very next transaction.
// Input: req_valid/req_ready carry one plaintext block per transaction.
// Output: rsp_valid/rsp_ready carry one ciphertext block per transaction.
// The accepting edge loads the block with the initial key addition, then
// ten rounds follow, one per cycle unless the last round stalls, on one
// shared round unit; the last round sets rsp_valid. A new block is taken only after the last round of the one before.
// The result sits in its own output register, so the next block is taken
// while a result still waits; if the receiver stalls, the last round holds
// until the output register frees up.
// Reset (synchronous, active high) drops any block in flight and clears
// rsp_valid.
module aes128_encrypt_block
   import aes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [HALF_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HALF_W-1:0] req_plain_high,
   input  logic [HALF_W-1:0] req_plain_low,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [HALF_W-1:0] rsp_cipher_high,
   output logic [HALF_W-1:0] rsp_cipher_low
);

   cmd_type cmd;

   // sequencer
   aes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // round datapath
   aes_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_plain_high  (req_plain_high),
      .req_plain_low   (req_plain_low),
      .cmd             (cmd),
      .rsp_cipher_high (rsp_cipher_high),
      .rsp_cipher_low  (rsp_cipher_low)
   );

endmodule

FILE: dv/aes128_encrypt_block_test.sv
`default_nettype none

module aes128_encrypt_block_test;
   import aes_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic              csr_index;
   logic [HALF_W-1:0] csr_data;
   logic              req_valid;
   logic              req_ready;
   logic [HALF_W-1:0] req_plain_high;
   logic [HALF_W-1:0] req_plain_low;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [HALF_W-1:0] rsp_cipher_high;
   logic [HALF_W-1:0] rsp_cipher_low;

   aes128_encrypt_block u_dut (.*);

   // clock, 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // one row of directed stimulus
   typedef struct {
      logic [127:0] key;
      logic [127:0] plain;
      logic [127:0] cipher;
      bit           known;
   } vector_type;

   logic [7:0]   sub_table [256];
   logic [127:0] round_keys [11];
   logic [63:0]  key_hi_reg, key_lo_reg;
   logic [127:0] cipher_queue [$];
   int           errors = 0;
   int           cycles = 0;
   int           blocks_sent = 0;
   int           blocks_checked = 0;
   int           key_writes = 0;
   bit           no_idle = 0;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   // s-box from the field inverse (x^254) and the affine map
   initial begin
      logic [7:0] inv, p, b;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         p = x[7:0];
         for (int e = 0; e < 8; e++) begin
            if (e != 0) inv = gf_mul(inv, p);
            p = gf_mul(p, p);
         end
         b = inv;
         sub_table[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                        ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
   end

   // key schedule into eleven round keys
   function automatic void expand_keys(input logic [63:0] kh, input logic [63:0] kl);
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      w[0] = kh[63:32];
      w[1] = kh[31:0];
      w[2] = kl[63:32];
      w[3] = kl[31:0];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sub_table[t[31:24]], sub_table[t[23:16]], sub_table[t[15:8]],
                 sub_table[t[7:0]]} ^ {rc, 24'h0};
            rc = gf_double(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++)
         round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
      logic [7:0] st [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) st[i] = plain[127-8*i -: 8] ^ round_keys[0][127-8*i -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // sub bytes and shift rows
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               t[r+4*c] = sub_table[st[r+4*((c+r)%4)]];
         st = t;
         // mix columns, skipped in the last round
         if (rnd != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= round_keys[rnd][127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   // wait until every transaction has come back, then let the round unit settle
   task automatic drain();
      req_valid <= 1'b0;
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable afterwards
   task automatic write_key(input logic idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      if (idx == CSR_KEY_HIGH) key_hi_reg = value;
      else key_lo_reg = value;
      expand_keys(key_hi_reg, key_lo_reg);
      key_writes++;
   endtask

   // change the key while idle; one half or both
   task automatic load_key(input logic [127:0] key);
      drain();
      if (key[127:64] !== key_hi_reg || key_writes == 0) write_key(CSR_KEY_HIGH, key[127:64]);
      if (key[63:0] !== key_lo_reg || key_writes < 2) write_key(CSR_KEY_LOW, key[63:0]);
      csr_wr_en <= 1'b0;
   endtask

   // one input transaction; the expected cipher (the known one, else the predicted one) is queued when it is accepted
   task automatic send_block(input logic [127:0] plain, input logic [127:0] cipher,
                             input bit known);
      int gap;
      logic [127:0] predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_plain_high <= plain[127:64];
      req_plain_low  <= plain[63:0];
      do @(posedge clock); while (!req_ready);
      predicted = encrypt_block(plain);
      if (known && predicted !== cipher)
         report_mismatch($sformatf("predictor gives %h for known vector %h", predicted, cipher));
      cipher_queue.push_back(known ? cipher : predicted);
      blocks_sent++;
   endtask

   // receiver: random stalls, checks each result transaction
   always @(posedge clock) begin
      int w;
      logic [127:0] exp_block;
      if (reset) begin
         rsp_ready <= 1'b0;
         w = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (cipher_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h_%h", rsp_cipher_high, rsp_cipher_low));
         end else begin
            exp_block = cipher_queue.pop_front();
            if (rsp_cipher_high !== exp_block[127:64])
               report_mismatch($sformatf("cipher_high %h, expected %h",
                                         rsp_cipher_high, exp_block[127:64]));
            if (rsp_cipher_low !== exp_block[63:0])
               report_mismatch($sformatf("cipher_low %h, expected %h",
                                         rsp_cipher_low, exp_block[63:0]));
            blocks_checked++;
         end
         w = draw_wait();
         rsp_ready <= (w == 0);
      end else if (w > 0) begin
         w--;
         rsp_ready <= (w == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("aes128_encrypt_block_test: errors");
         $finish;
      end
   end

   initial begin
      vector_type vectors [$];
      logic [127:0] key;
      int count;
      // zero key, the standard appendix vectors, then extremes
      vectors.push_back('{128'h0, 128'h0, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1});
      vectors.push_back('{128'h0, {128{1'b1}}, 128'h0, 0});
      vectors.push_back('{128'h2b7e151628aed2a6abf7158809cf4f3c,
                          128'h3243f6a8885a308d313198a2e0370734,
                          128'h3925841d02dc09fbdc118597196a0b32, 1});
      vectors.push_back('{128'h000102030405060708090a0b0c0d0e0f,
                          128'h00112233445566778899aabbccddeeff,
                          128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1});
      vectors.push_back('{128'h000102030405060708090a0b0c0d0e0f, 128'h0, 128'h0, 0});
      vectors.push_back('{128'h000102030405060708090a0b0c0d0e0f, {128{1'b1}}, 128'h0, 0});
      vectors.push_back('{{128{1'b1}}, 128'h0, 128'h0, 0});
      vectors.push_back('{{128{1'b1}}, {128{1'b1}}, 128'h0, 0});
      vectors.push_back('{{128{1'b1}}, 128'h8000000000000000_0000000000000001, 128'h0, 0});
      vectors.push_back('{{64'h0, {64{1'b1}}}, 128'h5555555555555555_aaaaaaaaaaaaaaaa, 128'h0, 0});
      vectors.push_back('{{{64{1'b1}}, 64'h0}, 128'haaaaaaaaaaaaaaaa_5555555555555555, 128'h0, 0});
      vectors.push_back('{{{64{1'b1}}, 64'h0}, 128'h0000000000000001_8000000000000000, 128'h0, 0});

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_KEY_HIGH;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_plain_high <= '0;
      req_plain_low  <= '0;
      key_hi_reg = '0;
      key_lo_reg = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (vectors[i]) begin
         if (i == 0 || vectors[i].key !== {key_hi_reg, key_lo_reg}) load_key(vectors[i].key);
         send_block(vectors[i].plain, vectors[i].cipher, vectors[i].known);
      end

      // random phases, each under its own key
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       key = {128{1'b1}};
            1:       key = '0;
            default: key = {$urandom, $urandom, $urandom, $urandom};
         endcase
         // sometimes only one half changes
         if (ph > 2 && $urandom_range(0, 2) == 0) key[63:0] = key_lo_reg;
         load_key(key);
         no_idle = (ph % 4 == 2);
         count = $urandom_range(100, 120);
         for (int n = 0; n < count; n++)
            send_block({$urandom, $urandom, $urandom, $urandom}, '0, 0);
      end
      no_idle = 0;

      drain();
      $display("sent %0d blocks under %0d key writes, %0d results checked",
               blocks_sent, key_writes, blocks_checked);
      if (errors == 0 && cipher_queue.size() == 0) begin
         $display("aes128_encrypt_block_test: clean");
      end else begin
         $display("aes128_encrypt_block_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: aes128_encrypt_block.f
hdl/aes_pkg.sv
hdl/aes_ctrl.sv
hdl/aes_dp.sv
hdl/aes128_encrypt_block.sv
dv/aes128_encrypt_block_test.sv
